@@ hw/rtl/rmfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Radio meter frame builder package
// Shared types, sequencer step addresses and the control program ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package rmfb_pkg;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  frame_len;
      logic [7:0]  channel;
      logic [7:0]  standard_id;
      logic [15:0] frame_ctrl;
      logic [7:0]  sequence_req;
      logic [15:0] pin_id;
      logic [55:0] dst_addr;
      logic [55:0] src_addr;
      logic [7:0]  cmd_id;
      logic [7:0]  data_byte;
      logic        last;
   } rmfb_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       payload_overflow;
   } rmfb_rsp_type;

   localparam logic REQ_HEADER  = 1'b0;
   localparam logic REQ_PAYLOAD = 1'b1;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   typedef enum logic [3:0] {
      SRC_LEN, SRC_CHAN, SRC_STD, SRC_HCS, SRC_CTRL_HI, SRC_CTRL_LO, SRC_SEQ,
      SRC_PIN_LO, SRC_PIN_HI, SRC_DST, SRC_SRC, SRC_CMD, SRC_DATA,
      SRC_FCS_LO, SRC_FCS_HI
   } byte_src_type;

   typedef enum logic [1:0] {
      BR_NEXT, BR_LAST, BR_END
   } branch_type;

   typedef struct packed {
      byte_src_type src;
      logic [2:0]   idx;
      logic         fin;
      branch_type   br;
   } ucode_type;

   localparam int          StepW       = 5;
   localparam logic [4:0]  STEP_HDR    = 5'd0;
   localparam logic [4:0]  STEP_CMD    = 5'd23;
   localparam logic [4:0]  STEP_DATA   = 5'd24;
   localparam logic [4:0]  STEP_FCS_LO = 5'd25;
   localparam logic [4:0]  STEP_FCS_HI = 5'd26;
   localparam logic [4:0]  STEP_DST0   = 5'd9;
   localparam logic [4:0]  STEP_SRC0   = 5'd16;

   function automatic ucode_type ucode_rom(input logic [4:0] step);
      ucode_type uc;
      uc = '{src: SRC_LEN, idx: 3'd0, fin: 1'b0, br: BR_NEXT};
      priority if (step >= STEP_DST0 && step < STEP_SRC0) begin
         uc.src = SRC_DST;
         uc.idx = 3'(step - STEP_DST0);
      end else if (step >= STEP_SRC0 && step < STEP_CMD) begin
         uc.src = SRC_SRC;
         uc.idx = 3'(step - STEP_SRC0);
      end else begin
         case (step)
            5'd0:        uc.src = SRC_LEN;
            5'd1:        uc.src = SRC_CHAN;
            5'd2:        uc.src = SRC_STD;
            5'd3:        uc.src = SRC_HCS;
            5'd4:        uc.src = SRC_CTRL_HI;
            5'd5:        uc.src = SRC_CTRL_LO;
            5'd6:        uc.src = SRC_SEQ;
            5'd7:        uc.src = SRC_PIN_LO;
            5'd8:        uc.src = SRC_PIN_HI;
            STEP_CMD: begin
               uc.src = SRC_CMD;
               uc.br  = BR_LAST;
            end
            STEP_DATA: begin
               uc.src = SRC_DATA;
               uc.br  = BR_LAST;
            end
            STEP_FCS_LO: uc.src = SRC_FCS_LO;
            STEP_FCS_HI: begin
               uc.src = SRC_FCS_HI;
               uc.fin = 1'b1;
               uc.br  = BR_END;
            end
            default:     uc.br = BR_END;
         endcase
      end
      return uc;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/radio_meter_frame_builder_crc16.sv @@
// ----------------------------------------------------------------------------
// Radio meter frame builder with CRC-16/X-25
// A small microcoded sequencer serializes frame bytes and appends the FCS.
// ----------------------------------------------------------------------------
// An accepted item is registered, and the sequencer then registers each of
// its bytes into the result register. Throughput: one byte per cycle while
// the result is not stalled; a header item runs the header and command steps,
// a stored payload byte the data step, both then the FCS steps when last,
// a dropped byte the FCS steps only if last; no item is taken while busy.
// Reset clears the sequencer, the CRC to 0xFFFF and the open frame state.
`default_nettype none

module radio_meter_frame_builder_crc16
   import rmfb_pkg::*;
#(
   parameter int MAX_PAYLOAD = 230
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire rmfb_req_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rmfb_rsp_type      rsp_item
);

   localparam int CntW = $clog2(MAX_PAYLOAD + 1);

   rmfb_req_type     req_ff, req_in;
   rmfb_rsp_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             busy_ff, busy_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [15:0]      crc_ff, crc_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             in_frame_ff, in_frame_in;

   ucode_type  uc;
   logic [7:0] cur_byte;
   logic       accept;
   logic       adv;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   assign uc        = ucode_rom(step_ff);
   assign accept    = req_valid && !busy_ff;
   assign adv       = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      unique case (uc.src)
         SRC_LEN:     cur_byte = req_ff.frame_len;
         SRC_CHAN:    cur_byte = req_ff.channel;
         SRC_STD:     cur_byte = req_ff.standard_id;
         SRC_HCS:     cur_byte = req_ff.frame_len ^ req_ff.channel ^ req_ff.standard_id;
         SRC_CTRL_HI: cur_byte = req_ff.frame_ctrl[15:8];
         SRC_CTRL_LO: cur_byte = req_ff.frame_ctrl[7:0];
         SRC_SEQ:     cur_byte = req_ff.sequence_req;
         SRC_PIN_LO:  cur_byte = req_ff.pin_id[7:0];
         SRC_PIN_HI:  cur_byte = req_ff.pin_id[15:8];
         SRC_DST:     cur_byte = req_ff.dst_addr[8*uc.idx +: 8];
         SRC_SRC:     cur_byte = req_ff.src_addr[8*uc.idx +: 8];
         SRC_CMD:     cur_byte = req_ff.cmd_id;
         SRC_DATA:    cur_byte = req_ff.data_byte;
         SRC_FCS_LO:  cur_byte = ~crc_ff[7:0];
         SRC_FCS_HI:  cur_byte = ~crc_ff[15:8];
         default:     cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      crc_in       = crc_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      in_frame_in  = in_frame_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         req_in = req_item;
         if (req_item.req_type == REQ_HEADER) begin
            busy_in     = 1'b1;
            step_in     = STEP_HDR;
            crc_in      = CRC_INIT;
            count_in    = '0;
            ovf_in      = 1'b0;
            in_frame_in = 1'b1;
         end else if (in_frame_ff) begin
            if (count_ff < CntW'(MAX_PAYLOAD)) begin
               busy_in  = 1'b1;
               step_in  = STEP_DATA;
               count_in = CntW'(count_ff + 1'b1);
            end else begin
               ovf_in = 1'b1;
               if (req_item.last) begin
                  busy_in = 1'b1;
                  step_in = STEP_FCS_LO;
               end
            end
         end
      end

      if (adv) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{out_byte: cur_byte, last_byte: uc.fin, payload_overflow: ovf_ff};
         if (uc.src != SRC_FCS_LO && uc.src != SRC_FCS_HI) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end
         unique case (uc.br)
            BR_NEXT: step_in = step_ff + 1'b1;
            BR_LAST: begin
               if (req_ff.last) begin
                  step_in = STEP_FCS_LO;
               end else begin
                  busy_in = 1'b0;
               end
            end
            BR_END: begin
               busy_in     = 1'b0;
               crc_in      = CRC_INIT;
               in_frame_in = 1'b0;
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         step_ff      <= STEP_HDR;
         crc_ff       <= CRC_INIT;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         in_frame_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         in_frame_ff  <= in_frame_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rmfb_checker.sv @@
// ----------------------------------------------------------------------------
// Radio meter frame builder port checker
// Watches the top level ports over time and reports rule violations.
// ----------------------------------------------------------------------------
`default_nettype none

module rmfb_sva
   import rmfb_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire rmfb_req_type req_item,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rmfb_rsp_type rsp_item
);

   // A stalled result transfer keeps its byte and flags.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // A header transfer always starts a busy sequence.
   a_hdr_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_item.req_type == REQ_HEADER |=> req_stall)
      else $error("header transfer did not start the sequencer");

   // After reset no result is offered.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

endmodule

bind radio_meter_frame_builder_crc16 rmfb_sva u_rmfb_sva (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

@@ bench/rmfb_checker.sv @@
// ----------------------------------------------------------------------------
// Radio meter frame builder checker
// Watches both channels of the frame builder. For every request transfer it
// works out the frame bytes due, with a running CRC-16/X-25, and compares each
// result transfer field by field against the oldest byte still due.
// ----------------------------------------------------------------------------
module rmfb_checker
   import rmfb_pkg::*;
#(
   parameter int MAX_PAYLOAD = 230
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire rmfb_req_type req_item,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rmfb_rsp_type rsp_item,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0]  crc_acc;
   int           payload_seen;
   logic         dropped_flag;
   logic         frame_open;
   rmfb_rsp_type frame_bytes_due[$];

   function automatic logic [15:0] crc_x25_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic fin);
      frame_bytes_due.push_back('{out_byte: b, last_byte: fin, payload_overflow: dropped_flag});
   endtask

   task automatic frame_byte(input logic [7:0] b);
      crc_acc = crc_x25_next(crc_acc, b);
      queue_byte(b, 1'b0);
   endtask

   task automatic predict_frame_bytes(input rmfb_req_type it);
      logic [15:0] fcs;
      if (it.req_type == REQ_HEADER) begin
         crc_acc      = CRC_INIT;
         payload_seen = 0;
         dropped_flag = 1'b0;
         frame_open   = 1'b1;
         frame_byte(it.frame_len);
         frame_byte(it.channel);
         frame_byte(it.standard_id);
         frame_byte(it.frame_len ^ it.channel ^ it.standard_id);
         frame_byte(it.frame_ctrl[15:8]);
         frame_byte(it.frame_ctrl[7:0]);
         frame_byte(it.sequence_req);
         frame_byte(it.pin_id[7:0]);
         frame_byte(it.pin_id[15:8]);
         for (int k = 0; k < 7; k++) begin
            frame_byte(it.dst_addr[8*k +: 8]);
         end
         for (int k = 0; k < 7; k++) begin
            frame_byte(it.src_addr[8*k +: 8]);
         end
         frame_byte(it.cmd_id);
      end else begin
         if (!frame_open) begin
            return;
         end
         if (payload_seen < MAX_PAYLOAD) begin
            payload_seen++;
            frame_byte(it.data_byte);
         end else begin
            dropped_flag = 1'b1;
         end
      end
      if (it.last) begin
         fcs = ~crc_acc;
         queue_byte(fcs[7:0], 1'b0);
         queue_byte(fcs[15:8], 1'b1);
         crc_acc    = CRC_INIT;
         frame_open = 1'b0;
      end
   endtask

   task automatic check_byte(input rmfb_rsp_type got);
      rmfb_rsp_type want;
      if (frame_bytes_due.size() == 0) begin
         $error("unexpected transfer: out_byte %02h, last_byte %0b, payload_overflow %0b",
                got.out_byte, got.last_byte, got.payload_overflow);
         fail_count++;
         return;
      end
      want = frame_bytes_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
         fail_count++;
      end
      if (got.last_byte !== want.last_byte) begin
         $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
         fail_count++;
      end
      if (got.payload_overflow !== want.payload_overflow) begin
         $error("payload_overflow: expected %0b, got %0b",
                want.payload_overflow, got.payload_overflow);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count   = 0;
         crc_acc      = CRC_INIT;
         payload_seen = 0;
         dropped_flag = 1'b0;
         frame_open   = 1'b0;
         frame_bytes_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_byte(rsp_item);
         end
         if (req_valid && !req_stall) begin
            predict_frame_bytes(req_item);
         end
      end
      pending_count <= frame_bytes_due.size();
   end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Radio meter frame builder testbench
// Drives header and payload requests into the frame builder: a directed set
// of edge cases, random frames and noise under several sender and receiver
// idling mixes, one of them with a long receiver hold-off, and one frame that
// overruns the payload limit. A checker beside the block predicts the bytes.
// ----------------------------------------------------------------------------
module tb_top
   import rmfb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAYLOAD_LIMIT = 230;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 400000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   rmfb_req_type req_item  = '0;
   logic         rsp_stall = 1'b0;
   logic         req_stall;
   logic         rsp_valid;
   rmfb_rsp_type rsp_item;

   int fail_count;
   int pending_count;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int items_done    = 0;
   int cycle_count   = 0;
   bit frame_live    = 1'b0;

   radio_meter_frame_builder_crc16 #(
      .MAX_PAYLOAD(PAYLOAD_LIMIT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   rmfb_checker #(
      .MAX_PAYLOAD(PAYLOAD_LIMIT)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("radio_meter_frame_builder_crc16 verification failed");
         $finish;
      end
   end

   // A pending hold-off request keeps stall high through one hold-off; otherwise stall follows stall_pct.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic rmfb_req_type random_fields();
      rmfb_req_type r;
      r.req_type     = 1'($urandom);
      r.frame_len    = 8'($urandom);
      r.channel      = 8'($urandom);
      r.standard_id  = 8'($urandom);
      r.frame_ctrl   = 16'($urandom);
      r.sequence_req = 8'($urandom);
      r.pin_id       = 16'($urandom);
      r.dst_addr     = 56'({$urandom, $urandom});
      r.src_addr     = 56'({$urandom, $urandom});
      r.cmd_id       = 8'($urandom);
      r.data_byte    = 8'($urandom);
      r.last         = 1'($urandom);
      return r;
   endfunction

   task automatic offer(input rmfb_req_type it);
      if (it.req_type == REQ_HEADER) begin
         frame_live = !it.last;
         items_done++;
      end else if (frame_live) begin
         frame_live = !it.last;
         items_done++;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic offer_kind(input logic kind, input logic fin);
      rmfb_req_type it;
      it          = random_fields();
      it.req_type = kind;
      it.last     = fin;
      offer(it);
   endtask

   task automatic random_frame();
      int n_pay;
      logic hdr_fin;
      hdr_fin = ($urandom_range(19) == 0);
      offer_kind(REQ_HEADER, hdr_fin);
      if (hdr_fin) begin
         return;
      end
      n_pay = $urandom_range(0, 10);
      repeat (n_pay) offer_kind(REQ_PAYLOAD, 1'b0);
      offer_kind(REQ_PAYLOAD, $urandom_range(9) != 0);
   endtask

   task automatic run_phase(input int n_items);
      int start;
      start = items_done;
      while (items_done - start < n_items) begin
         if ($urandom_range(9) < 8) begin
            random_frame();
         end else begin
            offer(random_fields());
         end
      end
   endtask

   initial begin
      rmfb_req_type it;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Payload with no open frame is ignored, with or without last.
      it          = '0;
      it.req_type = REQ_PAYLOAD;
      offer(it);
      it.last = 1'b1;
      offer(it);

      // All-zero header, then payload bytes at both extremes.
      it = '0;
      it.req_type = REQ_HEADER;
      offer(it);
      it = '0;
      it.req_type = REQ_PAYLOAD;
      offer(it);
      it.data_byte = 8'hFF;
      it.last      = 1'b1;
      offer(it);

      // All-ones header that closes the frame by itself.
      it          = '1;
      it.req_type = REQ_HEADER;
      offer(it);
      // Payload after the frame closed.
      it = '1;
      offer(it);

      // A new header abandons an open frame.
      offer_kind(REQ_HEADER, 1'b0);
      offer_kind(REQ_PAYLOAD, 1'b0);
      offer_kind(REQ_PAYLOAD, 1'b0);
      offer_kind(REQ_HEADER, 1'b0);
      offer_kind(REQ_PAYLOAD, 1'b1);
      offer_kind(REQ_HEADER, 1'b0);
      offer_kind(REQ_PAYLOAD, 1'b1);

      // No idling, with one long receiver hold-off while requests keep coming.
      hold_requests <= hold_requests + 1;
      run_phase(12);

      // Fill the payload to its limit, drop two bytes, then close on a dropped byte.
      offer_kind(REQ_HEADER, 1'b0);
      repeat (PAYLOAD_LIMIT) offer_kind(REQ_PAYLOAD, 1'b0);
      offer_kind(REQ_PAYLOAD, 1'b0);
      offer_kind(REQ_PAYLOAD, 1'b0);
      offer_kind(REQ_PAYLOAD, 1'b1);

      send_idle_pct = 76;
      run_phase(12);

      send_idle_pct = 0;
      stall_pct    <= 76;
      run_phase(12);

      send_idle_pct = 17;
      stall_pct    <= 17;
      run_phase(12);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("radio_meter_frame_builder_crc16 verification clean");
      end else begin
         $display("radio_meter_frame_builder_crc16 verification failed");
      end
      $finish;
   end

endmodule

@@ radio_meter_frame_builder_crc16.f @@
hw/rtl/rmfb_pkg.sv
hw/rtl/radio_meter_frame_builder_crc16.sv
hw/rtl/rmfb_checker.sv
bench/rmfb_checker.sv
bench/tb_top.sv
